// ===== design/array_binary_tree_engine_top_macros.svh =====
`ifndef ARRAY_BINARY_TREE_ENGINE_TOP_MACROS_SVH
`define ARRAY_BINARY_TREE_ENGINE_TOP_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define ABT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define ABT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/abt_pkg.sv =====
package abt_pkg;

  localparam int unsigned MAX_LEVELS = 6;
  localparam int unsigned DEPTH      = 1 << MAX_LEVELS;
  localparam int unsigned MAX_OUT    = DEPTH - 1;

  localparam logic signed [31:0] NULL_MARKER = -32'sd23;

  localparam logic [3:0] OP_INSERT = 4'd0;
  localparam logic [3:0] OP_DELETE = 4'd1;
  localparam logic [3:0] OP_EDIT   = 4'd2;
  localparam logic [3:0] OP_FIND   = 4'd3;
  localparam logic [3:0] OP_RIGHT  = 4'd4;
  localparam logic [3:0] OP_LEFT   = 4'd5;
  localparam logic [3:0] OP_PARENT = 4'd6;
  localparam logic [3:0] OP_IN     = 4'd7;
  localparam logic [3:0] OP_PRE    = 4'd8;
  localparam logic [3:0] OP_POST   = 4'd9;
  localparam logic [3:0] OP_LEVEL  = 4'd10;
  localparam logic [3:0] OP_COUNT  = 4'd11;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  typedef struct packed {
    logic [3:0]         operation;
    logic [5:0]         slot;
    logic [2:0]         level;
    logic [5:0]         level_offset;
    logic signed [31:0] value;
  } item_t;

  typedef struct packed {
    logic signed [31:0] node_value;
    logic [5:0]         found_slot;
    logic [5:0]         node_count;
    logic               root_empty;
    logic [2:0]         status;
    logic               last;
  } result_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_COUNT,
    CMD_ACCESS,
    CMD_RESP,
    CMD_DEL_HOLD,
    CMD_WALK,
    CMD_DEL_RESP,
    CMD_SCAN_RD,
    CMD_SCAN_CMP,
    CMD_FLUSH
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [3:0] op;
    logic       sweep_end;
    logic       lvl_ok;
    logic       scan_done;
    logic       walk_fin;
  } dp_status_t;

endpackage

// ===== design/abt_ctrl.sv =====
module abt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  abt_pkg::dp_status_t status_i,
  output abt_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_COUNT,
    S_ACCESS,
    S_RESP,
    S_DEL_HOLD,
    S_WALK,
    S_DEL_RESP,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DRAIN,
    S_FLUSH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o.cmd = abt_pkg::CMD_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.cmd = abt_pkg::CMD_LOAD;
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.cmd = abt_pkg::CMD_COUNT;
        if (status_i.sweep_end) begin
          if (status_i.op == abt_pkg::OP_FIND) begin
            state_d = S_SCAN_RD;
          end else if (status_i.op inside {[abt_pkg::OP_IN : abt_pkg::OP_LEVEL]}) begin
            state_d = S_WALK;
          end else if (status_i.op == abt_pkg::OP_DELETE && !status_i.lvl_ok) begin
            state_d = S_RESP;
          end else begin
            state_d = S_ACCESS;
          end
        end
      end
      S_ACCESS: begin
        cmd_o.cmd = abt_pkg::CMD_ACCESS;
        state_d = (status_i.op == abt_pkg::OP_DELETE) ? S_DEL_HOLD : S_RESP;
      end
      S_RESP: begin
        cmd_o.cmd = abt_pkg::CMD_RESP;
        state_d = S_IDLE;
      end
      S_DEL_HOLD: begin
        cmd_o.cmd = abt_pkg::CMD_DEL_HOLD;
        state_d = S_WALK;
      end
      S_WALK: begin
        cmd_o.cmd = abt_pkg::CMD_WALK;
        if (status_i.walk_fin) begin
          state_d = (status_i.op == abt_pkg::OP_DELETE) ? S_DEL_RESP : S_DRAIN;
        end
      end
      S_DEL_RESP: begin
        cmd_o.cmd = abt_pkg::CMD_DEL_RESP;
        state_d = S_IDLE;
      end
      S_SCAN_RD: begin
        cmd_o.cmd = abt_pkg::CMD_SCAN_RD;
        state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.cmd = abt_pkg::CMD_SCAN_CMP;
        state_d = status_i.scan_done ? S_IDLE : S_SCAN_RD;
      end
      S_DRAIN: begin
        state_d = S_FLUSH;
      end
      S_FLUSH: begin
        cmd_o.cmd = abt_pkg::CMD_FLUSH;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

// ===== design/abt_datapath.sv =====
`include "array_binary_tree_engine_top_macros.svh"

module abt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [2:0]          levels_i,
  input  abt_pkg::item_t      item_i,
  input  abt_pkg::ctrl_cmd_t  cmd_i,
  output abt_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output abt_pkg::result_t    result_o
);

  typedef enum logic [1:0] {
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_e;

  logic signed [31:0] mem [abt_pkg::DEPTH];
  logic signed [31:0] rdata_q;

  logic [3:0]         op_q;
  logic [5:0]         slot_q;
  logic [2:0]         level_q;
  logic [5:0]         offs_q;
  logic signed [31:0] val_q;

  logic [63:0]        nn_q, nn_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [6:0]         idx_q, idx_d;
  logic [5:0]         root_q, root_d;
  dir_e               dir_q, dir_d;
  logic [5:0]         n_q, n_d;
  logic signed [31:0] pend_q, pend_d;
  logic               have_pend_q, have_pend_d;
  logic               cap_q, cap_d;

  logic               res_valid_q, res_valid_d;
  logic signed [31:0] res_val_q, res_val_d;
  logic [5:0]         res_found_q, res_found_d;
  logic [2:0]         res_status_q, res_status_d;
  logic               res_last_q, res_last_d;

  logic [2:0]         lv_eff;
  logic [6:0]         size;
  logic [6:0]         lstart, lidx, lend;
  logic               lok;
  logic [6:0]         target;
  logic               tgt_nn;
  logic [5:0]         rd_addr;
  logic               we;
  logic               val_null;
  logic               ins_full, ins_bad;
  logic               par_ok;
  logic               emit, wfin, wclr;
  logic [6:0]         walk_idx;
  dir_e               walk_dir;
  logic signed [31:0] eff;
  logic               hit, scan_last;

  function automatic logic f_exists(input logic [6:0] c, input logic [6:0] sz,
                                    input logic [63:0] nn);
    return (c < sz) && nn[c[5:0]];
  endfunction

  always_comb begin
    if (levels_i == 3'd0) begin
      lv_eff = 3'd1;
    end else if (levels_i > 3'(abt_pkg::MAX_LEVELS)) begin
      lv_eff = 3'(abt_pkg::MAX_LEVELS);
    end else begin
      lv_eff = levels_i;
    end
  end

  assign size     = 7'd1 << lv_eff;
  assign val_null = (val_q == abt_pkg::NULL_MARKER);

  assign lstart = 7'd1 << (level_q - 3'd1);
  assign lidx   = lstart + {1'b0, offs_q} - 7'd1;
  assign lend   = {lstart[5:0], 1'b0} - 7'd1;
  assign lok    = (level_q != 3'd0) && (level_q <= 3'(abt_pkg::MAX_LEVELS)) &&
                  (offs_q != 6'd0) && (lidx <= lend) && f_exists(lidx, size, nn_q);

  always_comb begin
    case (op_q)
      abt_pkg::OP_INSERT: target = {1'b0, slot_q};
      abt_pkg::OP_EDIT:   target = lidx;
      abt_pkg::OP_DELETE: target = lidx;
      abt_pkg::OP_RIGHT:  target = {slot_q, 1'b1};
      abt_pkg::OP_LEFT:   target = {slot_q, 1'b0};
      abt_pkg::OP_PARENT: target = {2'b00, slot_q[5:1]};
      default:            target = 7'd0;
    endcase
  end

  assign tgt_nn   = f_exists(target, size, nn_q);
  assign par_ok   = (slot_q > 6'd1) && ({1'b0, slot_q} < size);
  assign ins_full = ({1'b0, cnt_q} == size - 7'd1);
  assign ins_bad  = (slot_q == 6'd0) || ({1'b0, slot_q} >= size) || nn_q[slot_q];

  always_comb begin
    emit     = 1'b0;
    wfin     = 1'b0;
    wclr     = 1'b0;
    walk_idx = idx_q;
    walk_dir = dir_q;
    if (op_q == abt_pkg::OP_LEVEL) begin
      emit     = nn_q[idx_q[5:0]];
      wfin     = (idx_q == size - 7'd1);
      walk_idx = idx_q + 7'd1;
    end else begin
      case (dir_q)
        DIR_DOWN: begin
          if (f_exists(idx_q, size, nn_q)) begin
            emit     = (op_q == abt_pkg::OP_PRE);
            wclr     = (op_q == abt_pkg::OP_DELETE);
            walk_idx = {idx_q[5:0], 1'b0};
            walk_dir = DIR_DOWN;
          end else if (idx_q == {1'b0, root_q}) begin
            wfin = 1'b1;
          end else begin
            walk_idx = idx_q >> 1;
            walk_dir = idx_q[0] ? DIR_RIGHT : DIR_LEFT;
          end
        end
        DIR_LEFT: begin
          emit     = (op_q == abt_pkg::OP_IN);
          walk_idx = {idx_q[5:0], 1'b1};
          walk_dir = DIR_DOWN;
        end
        DIR_RIGHT: begin
          emit = (op_q == abt_pkg::OP_POST);
          if (idx_q == {1'b0, root_q}) begin
            wfin = 1'b1;
          end else begin
            walk_idx = idx_q >> 1;
            walk_dir = idx_q[0] ? DIR_RIGHT : DIR_LEFT;
          end
        end
        default: begin
          wfin = 1'b1;
        end
      endcase
    end
    if (op_q != abt_pkg::OP_DELETE && n_q == 6'(abt_pkg::MAX_OUT)) begin
      emit = 1'b0;
      wfin = 1'b1;
    end
  end

  assign eff       = nn_q[idx_q[5:0]] ? rdata_q : abt_pkg::NULL_MARKER;
  assign hit       = (eff == val_q);
  assign scan_last = (idx_q == size - 7'd1);

  always_comb begin
    case (cmd_i.cmd)
      abt_pkg::CMD_ACCESS: rd_addr = target[5:0];
      default:             rd_addr = idx_q[5:0];
    endcase
  end

  assign we = (cmd_i.cmd == abt_pkg::CMD_RESP) &&
              (((op_q == abt_pkg::OP_INSERT) && !ins_full && !ins_bad) ||
               ((op_q == abt_pkg::OP_EDIT) && lok));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[target[5:0]] <= val_q;
    end
    rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd == abt_pkg::CMD_LOAD) begin
      op_q    <= item_i.operation;
      slot_q  <= item_i.slot;
      level_q <= item_i.level;
      offs_q  <= item_i.level_offset;
      val_q   <= item_i.value;
    end
  end

  always_comb begin
    nn_d         = nn_q;
    cnt_d        = cnt_q;
    idx_d        = idx_q;
    root_d       = root_q;
    dir_d        = dir_q;
    n_d          = n_q;
    pend_d       = pend_q;
    have_pend_d  = have_pend_q;
    cap_d        = 1'b0;
    res_valid_d  = 1'b0;
    res_val_d    = res_val_q;
    res_found_d  = 6'd0;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;

    if (cap_q) begin
      if (have_pend_q) begin
        res_valid_d  = 1'b1;
        res_val_d    = pend_q;
        res_status_d = abt_pkg::ST_OK;
        res_last_d   = 1'b0;
      end
      pend_d      = rdata_q;
      have_pend_d = 1'b1;
    end

    case (cmd_i.cmd)
      abt_pkg::CMD_LOAD: begin
        cnt_d       = 6'd0;
        idx_d       = 7'd1;
        root_d      = 6'd1;
        dir_d       = DIR_DOWN;
        n_d         = 6'd0;
        have_pend_d = 1'b0;
      end
      abt_pkg::CMD_COUNT: begin
        if (f_exists(idx_q, size, nn_q)) begin
          cnt_d = cnt_q + 6'd1;
        end
        idx_d = status_o.sweep_end ? 7'd1 : idx_q + 7'd1;
      end
      abt_pkg::CMD_RESP: begin
        res_valid_d = 1'b1;
        res_last_d  = 1'b1;
        res_val_d   = 32'sd0;
        case (op_q)
          abt_pkg::OP_INSERT: begin
            if (ins_full) begin
              res_status_d = abt_pkg::ST_FULL;
            end else if (ins_bad) begin
              res_status_d = abt_pkg::ST_INVALID;
            end else begin
              res_status_d       = abt_pkg::ST_OK;
              res_val_d          = val_q;
              nn_d[target[5:0]]  = !val_null;
              cnt_d              = cnt_q + {5'd0, !val_null};
            end
          end
          abt_pkg::OP_EDIT: begin
            if (lok) begin
              res_status_d      = abt_pkg::ST_OK;
              res_val_d         = rdata_q;
              nn_d[target[5:0]] = !val_null;
              cnt_d             = cnt_q - {5'd0, val_null};
            end else begin
              res_status_d = abt_pkg::ST_INVALID;
            end
          end
          abt_pkg::OP_RIGHT, abt_pkg::OP_LEFT: begin
            res_val_d    = tgt_nn ? rdata_q : abt_pkg::NULL_MARKER;
            res_status_d = tgt_nn ? abt_pkg::ST_OK : abt_pkg::ST_NOTFOUND;
          end
          abt_pkg::OP_PARENT: begin
            res_val_d    = (par_ok && tgt_nn) ? rdata_q : abt_pkg::NULL_MARKER;
            res_status_d = (par_ok && tgt_nn) ? abt_pkg::ST_OK : abt_pkg::ST_NOTFOUND;
          end
          abt_pkg::OP_COUNT: begin
            res_status_d = abt_pkg::ST_OK;
          end
          default: begin
            res_status_d = abt_pkg::ST_INVALID;
          end
        endcase
      end
      abt_pkg::CMD_DEL_HOLD: begin
        pend_d = rdata_q;
        root_d = lidx[5:0];
        idx_d  = lidx;
        dir_d  = DIR_DOWN;
      end
      abt_pkg::CMD_WALK: begin
        idx_d = walk_idx;
        dir_d = walk_dir;
        if (wclr) begin
          nn_d[idx_q[5:0]] = 1'b0;
          cnt_d            = cnt_q - 6'd1;
        end
        if (emit) begin
          cap_d = 1'b1;
          n_d   = n_q + 6'd1;
        end
      end
      abt_pkg::CMD_DEL_RESP: begin
        res_valid_d  = 1'b1;
        res_val_d    = pend_q;
        res_status_d = abt_pkg::ST_OK;
        res_last_d   = 1'b1;
      end
      abt_pkg::CMD_SCAN_CMP: begin
        idx_d = idx_q + 7'd1;
        if (hit) begin
          res_valid_d  = 1'b1;
          res_val_d    = val_q;
          res_found_d  = idx_q[5:0];
          res_status_d = abt_pkg::ST_OK;
          res_last_d   = 1'b1;
        end else if (scan_last) begin
          res_valid_d  = 1'b1;
          res_val_d    = val_q;
          res_status_d = abt_pkg::ST_NOTFOUND;
          res_last_d   = 1'b1;
        end
      end
      abt_pkg::CMD_FLUSH: begin
        res_valid_d  = 1'b1;
        res_last_d   = 1'b1;
        res_val_d    = have_pend_q ? pend_q : abt_pkg::NULL_MARKER;
        res_status_d = have_pend_q ? abt_pkg::ST_OK : abt_pkg::ST_EMPTY;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nn_q        <= '0;
      cnt_q       <= '0;
      idx_q       <= 7'd1;
      root_q      <= 6'd1;
      dir_q       <= DIR_DOWN;
      n_q         <= '0;
      have_pend_q <= 1'b0;
      cap_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      nn_q        <= nn_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      root_q      <= root_d;
      dir_q       <= dir_d;
      n_q         <= n_d;
      have_pend_q <= have_pend_d;
      cap_q       <= cap_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q       <= pend_d;
    res_val_q    <= res_val_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign status_o.op        = op_q;
  assign status_o.sweep_end = (idx_q == 7'(abt_pkg::MAX_OUT));
  assign status_o.lvl_ok    = lok;
  assign status_o.scan_done = hit || scan_last;
  assign status_o.walk_fin  = wfin;

  assign result_valid_o       = res_valid_q;
  assign result_o.node_value  = res_val_q;
  assign result_o.found_slot  = res_found_q;
  assign result_o.node_count  = cnt_q;
  assign result_o.root_empty  = !nn_q[1];
  assign result_o.status      = res_status_q;
  assign result_o.last        = res_last_q;

  `ABT_ASSERT_IMP(a_emit_in_range, (cmd_i.cmd == abt_pkg::CMD_WALK) && emit, idx_q < size, "walk emits a slot outside the tree")
  `ABT_ASSERT_NXT(a_cap_holds, cap_q, have_pend_q, "captured node not held as pending")
  `ABT_ASSERT_IMP(a_empty_flush, (cmd_i.cmd == abt_pkg::CMD_FLUSH) && !have_pend_q, n_q == 6'd0, "empty traversal after emitting nodes")

endmodule

// ===== design/array_binary_tree_engine_top.sv =====
// channel   | direction | handshake                 | payload
// ----------+-----------+---------------------------+------------------------
// command   | in        | start high, busy low      | item_i   (abt_pkg::item_t)
// result    | out       | result_valid_o, one cycle | result_o (abt_pkg::result_t)
// register  | in/out    | APB, write on access      | pwdata / prdata
//
// Every operation first sweeps the 63 presence bits to count nodes.
// Single-node operations then pass an access state and a response state via the store read port.
// Find then reads and compares one slot at a time until a match or the last slot of the tree.
// Traversals and subtree delete walk the tree one move per cycle.
// Reset empties all nodes at once and sets levels_in_use to 6.
// Results cannot be stalled; start is taken only while busy is low.
module array_binary_tree_engine_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  abt_pkg::item_t   item_i,
  output logic             result_valid_o,
  output abt_pkg::result_t result_o,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [2:0]          levels_q;
  abt_pkg::ctrl_cmd_t  cmd;
  abt_pkg::dp_status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= 3'(abt_pkg::MAX_LEVELS);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      levels_q <= pwdata[2:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {29'd0, levels_q};

  abt_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  abt_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .levels_i       (levels_q),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== dv/tb.sv =====
module tb;
  import abt_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES   = 300;

  class tree_scoreboard;
    logic signed [31:0] store[DEPTH];
    logic [2:0]         levels;
    logic signed [31:0] trail[$];
    result_t            pending_results[$];
    int                 errors;
    int                 transactions;
    int                 results;

    function new();
      foreach (store[i]) store[i] = NULL_MARKER;
      levels = 3'd6;
    endfunction

    function int unsigned span();
      int unsigned lv;
      lv = levels;
      if (lv < 1) lv = 1;
      if (lv > MAX_LEVELS) lv = MAX_LEVELS;
      return 1 << lv;
    endfunction

    function logic [5:0] live_count();
      int n;
      n = 0;
      for (int i = 1; i < span(); i++) if (store[i] != NULL_MARKER) n++;
      return n[5:0];
    endfunction

    function void push_result(logic signed [31:0] nv, logic [5:0] fs, logic [2:0] st,
                              logic last);
      result_t r;
      r.node_value = nv;
      r.found_slot = fs;
      r.node_count = live_count();
      r.root_empty = (store[1] == NULL_MARKER);
      r.status     = st;
      r.last       = last;
      pending_results = {pending_results, r};
    endfunction

    function void clear_subtree(int idx);
      if (idx >= span() || store[idx] == NULL_MARKER) return;
      store[idx] = NULL_MARKER;
      clear_subtree(2 * idx);
      clear_subtree(2 * idx + 1);
    endfunction

    function void walk_tree(int idx, logic [3:0] order);
      if (idx >= span() || store[idx] == NULL_MARKER) return;
      if (order == OP_PRE && trail.size() < MAX_OUT) trail = {trail, store[idx]};
      walk_tree(2 * idx, order);
      if (order == OP_IN && trail.size() < MAX_OUT) trail = {trail, store[idx]};
      walk_tree(2 * idx + 1, order);
      if (order == OP_POST && trail.size() < MAX_OUT) trail = {trail, store[idx]};
    endfunction

    function int level_slot(logic [2:0] level, logic [5:0] offset);
      int first, final_idx, idx;
      if (level < 1 || level > MAX_LEVELS) return 0;
      if (offset < 1) return 0;
      first     = 1 << (level - 1);
      final_idx = (1 << level) - 1;
      idx       = first + offset - 1;
      if (idx > final_idx || idx >= span()) return 0;
      if (store[idx] == NULL_MARKER) return 0;
      return idx;
    endfunction

    function void note_item(item_t it);
      int                 size, idx;
      logic signed [31:0] v;
      bit                 hit;
      size = span();
      transactions++;
      case (it.operation)
        OP_INSERT: begin
          if (live_count() == size - 1) push_result(0, 0, ST_FULL, 1'b1);
          else if (it.slot == 0 || it.slot >= size || store[it.slot] != NULL_MARKER)
            push_result(0, 0, ST_INVALID, 1'b1);
          else begin
            store[it.slot] = it.value;
            push_result(it.value, 0, ST_OK, 1'b1);
          end
        end
        OP_DELETE, OP_EDIT: begin
          idx = level_slot(it.level, it.level_offset);
          if (idx == 0) push_result(0, 0, ST_INVALID, 1'b1);
          else begin
            v = store[idx];
            if (it.operation == OP_DELETE) clear_subtree(idx);
            else store[idx] = it.value;
            push_result(v, 0, ST_OK, 1'b1);
          end
        end
        OP_FIND: begin
          hit = 0;
          for (int i = 1; i < size && !hit; i++) begin
            if (store[i] == it.value) begin
              hit = 1;
              push_result(it.value, i[5:0], ST_OK, 1'b1);
            end
          end
          if (!hit) push_result(it.value, 0, ST_NOTFOUND, 1'b1);
        end
        OP_RIGHT, OP_LEFT: begin
          idx = 2 * it.slot + ((it.operation == OP_RIGHT) ? 1 : 0);
          v = (idx < size) ? store[idx] : NULL_MARKER;
          push_result(v, 0, (v == NULL_MARKER) ? ST_NOTFOUND : ST_OK, 1'b1);
        end
        OP_PARENT: begin
          v = (it.slot <= 1 || it.slot >= size) ? NULL_MARKER : store[it.slot / 2];
          push_result(v, 0, (v == NULL_MARKER) ? ST_NOTFOUND : ST_OK, 1'b1);
        end
        OP_IN, OP_PRE, OP_POST, OP_LEVEL: begin
          trail.delete();
          if (it.operation == OP_LEVEL) begin
            for (int i = 1; i < size && trail.size() < MAX_OUT; i++)
              if (store[i] != NULL_MARKER) trail = {trail, store[i]};
          end else begin
            walk_tree(1, it.operation);
          end
          if (trail.size() == 0) push_result(NULL_MARKER, 0, ST_EMPTY, 1'b1);
          foreach (trail[k]) push_result(trail[k], 0, ST_OK, k == trail.size() - 1);
        end
        OP_COUNT: push_result(0, 0, ST_OK, 1'b1);
        default:  push_result(0, 0, ST_INVALID, 1'b1);
      endcase
    endfunction

    function void check_result(result_t r);
      result_t e;
      results++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %p", $realtime, r);
        return;
      end
      e = pending_results.pop_front();
      if (r.node_value !== e.node_value || r.found_slot !== e.found_slot ||
          r.node_count !== e.node_count || r.root_empty !== e.root_empty ||
          r.status !== e.status || r.last !== e.last) begin
        errors++;
        $display("%0t: mismatch expected %p actual %p", $realtime, e, r);
      end
    endfunction
  endclass

  logic    clk_i;
  logic    rst_ni;
  logic    start;
  logic    busy;
  item_t   item_i;
  logic    result_valid_o;
  result_t result_o;
  logic    psel;
  logic    penable;
  logic    pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tree_scoreboard sb;
  int unsigned    quiet_cycles;
  bit             no_idle;

  array_binary_tree_engine_top dut (.*);

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) sb.note_item(item_i);
      if (result_valid_o) sb.check_result(result_o);
      if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  task automatic send_item(item_t it);
    if (!no_idle && $urandom_range(99) < 15) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [2:0] lv);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= '0;
    pwdata  <= {29'd0, lv};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.levels = lv;
    @(negedge clk_i);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[2:0] !== lv) begin
      sb.errors++;
      $display("%0t: register readback expected %0d actual %0d", $realtime, lv, prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic item_t make_item(logic [3:0] op, logic [5:0] slot, logic [2:0] level,
                                      logic [5:0] offset, logic signed [31:0] value);
    item_t it;
    it.operation    = op;
    it.slot         = slot;
    it.level        = level;
    it.level_offset = offset;
    it.value        = value;
    return it;
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(7))
      0:       return NULL_MARKER;
      1:       return 32'sh7fffffff;
      2:       return 32'sh80000000;
      3:       return sb.store[$urandom_range(sb.span() - 1, 1)];
      default: return $urandom;
    endcase
  endfunction

  function automatic item_t random_item();
    int unsigned size, pick;
    logic [3:0]  op;
    logic [5:0]  slot;
    logic [2:0]  level;
    logic [5:0]  offset;
    size = sb.span();
    pick = $urandom_range(99);
    if (pick < 32)      op = OP_INSERT;
    else if (pick < 42) op = OP_DELETE;
    else if (pick < 52) op = OP_EDIT;
    else if (pick < 62) op = OP_FIND;
    else if (pick < 77) op = OP_RIGHT + 4'($urandom_range(2));
    else if (pick < 90) op = OP_IN + 4'($urandom_range(3));
    else if (pick < 95) op = OP_COUNT;
    else                op = 4'($urandom_range(15, 12));
    slot  = ($urandom_range(9) < 8) ? 6'($urandom_range(size - 1, 1)) : 6'($urandom);
    level = ($urandom_range(9) < 8) ? 3'($urandom_range(MAX_LEVELS, 1)) : 3'($urandom);
    if ($urandom_range(9) < 8 && level >= 1 && level <= MAX_LEVELS)
      offset = 6'($urandom_range(1 << (level - 1), 1));
    else
      offset = 6'($urandom);
    return make_item(op, slot, level, offset, pick_value());
  endfunction

  initial begin
    logic [2:0] phase_levels[8];
    phase_levels = '{3'd6, 3'd3, 3'd1, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6};
    sb           = new();
    quiet_cycles = 0;
    no_idle      = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    item_i       = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_item(make_item(OP_IN, 0, 0, 0, 0));
    send_item(make_item(OP_LEVEL, 0, 0, 0, 0));
    send_item(make_item(OP_INSERT, 0, 1, 1, 5));
    send_item(make_item(OP_INSERT, 1, 1, 1, 32'sh7fffffff));
    send_item(make_item(OP_INSERT, 1, 1, 1, 7));
    send_item(make_item(OP_INSERT, 2, 0, 0, 32'sh80000000));
    send_item(make_item(OP_INSERT, 3, 0, 0, NULL_MARKER));
    send_item(make_item(OP_INSERT, 63, 7, 63, -32'sd1));
    send_item(make_item(OP_FIND, 0, 0, 0, NULL_MARKER));
    send_item(make_item(OP_FIND, 0, 0, 0, 32'sh80000000));
    send_item(make_item(OP_FIND, 0, 0, 0, 12345));
    send_item(make_item(OP_RIGHT, 31, 0, 0, 0));
    send_item(make_item(OP_LEFT, 1, 0, 0, 0));
    send_item(make_item(OP_LEFT, 63, 0, 0, 0));
    send_item(make_item(OP_PARENT, 1, 0, 0, 0));
    send_item(make_item(OP_PARENT, 2, 0, 0, 0));
    send_item(make_item(OP_PARENT, 62, 0, 0, 0));
    send_item(make_item(OP_EDIT, 0, 0, 1, 9));
    send_item(make_item(OP_EDIT, 0, 2, 3, 9));
    send_item(make_item(OP_EDIT, 0, 2, 1, NULL_MARKER));
    send_item(make_item(OP_PRE, 0, 0, 0, 0));
    send_item(make_item(OP_POST, 0, 0, 0, 0));
    send_item(make_item(OP_DELETE, 0, 1, 1, 0));
    send_item(make_item(OP_COUNT, 0, 0, 0, 0));
    send_item(make_item(4'd15, 63, 7, 63, -32'sd1));

    foreach (phase_levels[p]) begin
      write_levels(phase_levels[p]);
      if (phase_levels[p] == 3'd1) begin
        send_item(make_item(OP_INSERT, 1, 1, 1, 3));
        send_item(make_item(OP_INSERT, 1, 1, 1, 4));
      end
      no_idle = (p == 3);
      for (int n = 0; n < 56; n++) begin
        if (p == 5 && n == 20) drain();
        send_item(random_item());
      end
    end
    no_idle = 0;

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("tb: %0d commands, %0d results over 8 tree-depth settings incl. 0 and 7",
             sb.transactions, sb.results);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0t: %0d errors, %0d results outstanding", $realtime, sb.errors,
               sb.pending_results.size());
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
